// ----- sv/ftl_pkg.sv -----
// ----------------------------------------------------------------------------
// ftl_pkg
// Shared types and constants of the forwarding table lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package ftl_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned NB_W    = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEF_NEIGHBOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_VALID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_DELAY    = 2'd2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [NB_W-1:0]    neighbor_id;
    logic [DELAY_W-1:0] entry_delay;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/ftl_req_if.sv -----
// ----------------------------------------------------------------------------
// ftl_req_if
// Request channel: command, address and the mapping carried by an insert.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftl_req_if import ftl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [ADDR_W-1:0]  address;
  logic [NB_W-1:0]    neighbor_id;
  logic [DELAY_W-1:0] entry_delay;

  modport source (output valid, command, address, neighbor_id, entry_delay, input ready);
  modport sink   (input valid, command, address, neighbor_id, entry_delay, output ready);
endinterface

`default_nettype wire

// ----- sv/ftl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ftl_rsp_if
// Response channel: next hop, delay, hit flag, status and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftl_rsp_if import ftl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NB_W-1:0]    next_hop;
  logic               next_hop_valid;
  logic [DELAY_W-1:0] hop_delay;
  logic               hit;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, next_hop, next_hop_valid, hop_delay, hit, status,
                  entry_count, input ready);
  modport sink   (input valid, next_hop, next_hop_valid, hop_delay, hit, status,
                  entry_count, output ready);
endinterface

`default_nettype wire

// ----- sv/forwarding_table_lookup_core.sv -----
// ----------------------------------------------------------------------------
// forwarding_table_lookup_core
// Exact-match forwarding table with a default route, scanned one entry a cycle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  req_i     in   valid / ready      command, address, neighbor_id, entry_delay
//  rsp_o     out  valid / ready      next_hop, next_hop_valid, hop_delay, hit,
//                                    status, entry_count
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
//  a request runs from accept through the scan (skipped when no entries) and
//  the finish step to idle; the scan compares k entries: the matching position
//  plus one, or the entry count on a miss (at most TABLE_DEPTH); one comparator
//  walks the entry ram whose registered read port delivers one entry a cycle.
//  reset clears the count and the default route; table contents need no clear.
//  a stalled response holds; a new request is taken while it waits, and the
//  finish step waits for the response register to be free.
// ----------------------------------------------------------------------------
`default_nettype none

module forwarding_table_lookup_core import ftl_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ftl_req_if.sink                    req_i,
  ftl_rsp_if.source                  rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [NB_W-1:0]    def_nb_q;
  logic               def_valid_q;
  logic [DELAY_W-1:0] def_delay_q;

  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   idx_q;

  logic               cmd_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [NB_W-1:0]    nb_q;
  logic [DELAY_W-1:0] dl_q;
  logic               hit_q;
  logic [NB_W-1:0]    found_nb_q;
  logic [DELAY_W-1:0] found_dl_q;

  logic               out_valid_q;
  logic [NB_W-1:0]    out_nb_q;
  logic               out_nbv_q;
  logic [DELAY_W-1:0] out_dl_q;
  logic               out_hit_q;
  status_e            out_status_q;
  logic [CNT_W-1:0]   out_count_q;

  logic               accept;
  logic               out_free;
  logic               finish;
  logic               full;
  logic               do_write;
  logic               match;
  logic               last;
  logic [IDX_W-1:0]   raddr;
  entry_t             wr_entry;
  entry_t             rd_entry;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign finish   = (state_q == ST_DONE) && out_free;
  assign full     = count_q >= CNT_W'(TABLE_DEPTH);
  assign do_write = finish && (cmd_q == CMD_INSERT) && !hit_q && !full;
  assign match    = rd_entry.address == addr_q;
  assign last     = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign raddr    = (state_q == ST_IDLE) ? '0 : idx_q + IDX_W'(1);

  assign req_i.ready = (state_q == ST_IDLE);

  assign wr_entry.address     = addr_q;
  assign wr_entry.neighbor_id = nb_q;
  assign wr_entry.entry_delay = dl_q;

  ftl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      def_nb_q    <= '0;
      def_valid_q <= 1'b0;
      def_delay_q <= '0;
    end else begin
      state_q <= state_d;
      if (do_write) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEF_NEIGHBOR: def_nb_q    <= cfg_data_i[NB_W-1:0];
          CFG_DEF_VALID:    def_valid_q <= cfg_data_i[0];
          CFG_DEF_DELAY:    def_delay_q <= cfg_data_i[DELAY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // request capture and scan datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      addr_q <= req_i.address;
      nb_q   <= req_i.neighbor_id;
      dl_q   <= req_i.entry_delay;
      hit_q  <= 1'b0;
      idx_q  <= '0;
    end else if (state_q == ST_SCAN) begin
      idx_q <= idx_q + IDX_W'(1);
      if (match) begin
        hit_q      <= 1'b1;
        found_nb_q <= rd_entry.neighbor_id;
        found_dl_q <= rd_entry.entry_delay;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_hit_q   <= hit_q;
      out_count_q <= do_write ? count_q + CNT_W'(1) : count_q;
      if (cmd_q == CMD_INSERT) begin
        out_nb_q  <= '0;
        out_nbv_q <= 1'b0;
        out_dl_q  <= '0;
        if (hit_q) begin
          out_status_q <= STAT_DUP;
        end else if (full) begin
          out_status_q <= STAT_FULL;
        end else begin
          out_status_q <= STAT_OK;
        end
      end else begin
        out_status_q <= STAT_OK;
        if (hit_q) begin
          out_nb_q  <= found_nb_q;
          out_nbv_q <= 1'b1;
          out_dl_q  <= found_dl_q;
        end else begin
          out_nb_q  <= def_valid_q ? def_nb_q : '0;
          out_nbv_q <= def_valid_q;
          out_dl_q  <= def_delay_q;
        end
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.next_hop       = out_nb_q;
  assign rsp_o.next_hop_valid = out_nbv_q;
  assign rsp_o.hop_delay      = out_dl_q;
  assign rsp_o.hit            = out_hit_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.entry_count    = COUNT_W'(out_count_q);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(idx_q) < count_q))
    else $error("scan index beyond stored entries");

  a_reject_no_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != STAT_OK)) |-> !rsp_o.next_hop_valid)
    else $error("rejected insert carries a route");

endmodule

`default_nettype wire

// ----- sv/ftl_ram.sv -----
// ----------------------------------------------------------------------------
// ftl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ftl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the forwarding table lookup core.
// A directed table fills the forwarding table to the brim and walks the
// duplicate, table-full and default-route cases. After it come random lookup
// and insert phases, with the default-route registers changed between phases.
// Responses are checked against fixed values or a local copy of the table.
// ----------------------------------------------------------------------------

module tb import ftl_pkg::*; ();

  localparam int PHASE_ITEMS  = 115;
  localparam int RAND_PHASES  = 5;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [NB_W-1:0]    next_hop;
    logic               next_hop_valid;
    logic [DELAY_W-1:0] hop_delay;
    logic               hit;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
  } route_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  cmd;
    logic [ADDR_W-1:0]     addr;
    logic [NB_W-1:0]       nb;
    logic [DELAY_W-1:0]    dl;
    bit                    typed;
    route_t                want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ftl_req_if req_bus ();
  ftl_rsp_if rsp_bus ();

  forwarding_table_lookup_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 2 ns period
  always #1 clk_i = ~clk_i;

  // local copy of the forwarding table and the default route
  logic [ADDR_W-1:0]  fwd_addr [TABLE_DEPTH];
  logic [NB_W-1:0]    fwd_nb   [TABLE_DEPTH];
  logic [DELAY_W-1:0] fwd_delay[TABLE_DEPTH];
  int                 fwd_count = 0;
  logic [NB_W-1:0]    dflt_nb = '0;
  logic               dflt_valid = 1'b0;
  logic [DELAY_W-1:0] dflt_delay = '0;

  route_t pending_routes[$];
  int     error_count = 0;
  int     requests_taken = 0;
  int     n_hits = 0, n_misses = 0, n_stored = 0, n_dups = 0, n_full = 0;
  int     n_settings = 0;
  int     burst_left = 0;
  int     quiet_cycles = 0;
  logic   hold_rsp = 1'b0;
  logic [7:0] stall_phase = '0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic route_t predict_route(input logic cmd, input logic [ADDR_W-1:0] addr,
                                           input logic [NB_W-1:0] nb,
                                           input logic [DELAY_W-1:0] dl);
    route_t r;
    int     slot;
    int     k;
    r.next_hop       = '0;
    r.next_hop_valid = 1'b0;
    r.hop_delay      = '0;
    r.hit            = 1'b0;
    r.status         = STAT_OK;
    slot = -1;
    for (k = 0; k < fwd_count; k++) begin
      if (slot < 0 && fwd_addr[k] == addr) slot = k;
    end
    if (cmd == CMD_INSERT) begin
      if (slot >= 0) begin
        r.hit    = 1'b1;
        r.status = STAT_DUP;
        n_dups++;
      end else if (fwd_count >= TABLE_DEPTH) begin
        r.status = STAT_FULL;
        n_full++;
      end else begin
        fwd_addr[fwd_count]  = addr;
        fwd_nb[fwd_count]    = nb;
        fwd_delay[fwd_count] = dl;
        fwd_count++;
        n_stored++;
      end
    end else if (slot >= 0) begin
      r.hit            = 1'b1;
      r.next_hop       = fwd_nb[slot];
      r.next_hop_valid = 1'b1;
      r.hop_delay      = fwd_delay[slot];
      n_hits++;
    end else begin
      // miss falls back to the default route; delay is passed even without one
      r.next_hop_valid = dflt_valid;
      r.next_hop       = dflt_valid ? dflt_nb : '0;
      r.hop_delay      = dflt_delay;
      n_misses++;
    end
    r.entry_count = COUNT_W'(fwd_count);
    return r;
  endfunction

  function automatic probe_t req_row(input logic cmd, input logic [ADDR_W-1:0] addr,
                                     input logic [NB_W-1:0] nb,
                                     input logic [DELAY_W-1:0] dl);
    probe_t p;
    p.kind  = ROW_REQUEST;
    p.cmd   = cmd;
    p.addr  = addr;
    p.nb    = nb;
    p.dl    = dl;
    p.typed = 1'b0;
    return p;
  endfunction

  function automatic probe_t chk_row(input logic cmd, input logic [ADDR_W-1:0] addr,
                                     input logic [NB_W-1:0] nb,
                                     input logic [DELAY_W-1:0] dl, input route_t want);
    probe_t p;
    p       = req_row(cmd, addr, nb, dl);
    p.typed = 1'b1;
    p.want  = want;
    return p;
  endfunction

  function automatic probe_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    probe_t p;
    p.kind     = ROW_CONFIG;
    p.reg_idx  = idx;
    p.reg_data = data;
    return p;
  endfunction

  // offer one request in the current burst, then maybe open a gap
  task automatic offer_request(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [NB_W-1:0] nb, input logic [DELAY_W-1:0] dl,
                               input bit typed, input route_t want);
    route_t model_out;
    int     gap;
    req_bus.valid       <= 1'b1;
    req_bus.command     <= cmd;
    req_bus.address     <= addr;
    req_bus.neighbor_id <= nb;
    req_bus.entry_delay <= dl;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    model_out = predict_route(cmd, addr, nb, dl);
    pending_routes.push_back(typed ? want : model_out);
    requests_taken++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_table_idle();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_routes.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DEF_NEIGHBOR: dflt_nb    = data[NB_W-1:0];
      CFG_DEF_VALID:    dflt_valid = data[0];
      CFG_DEF_DELAY:    dflt_delay = data[DELAY_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // response checker
  always @(posedge clk_i) begin
    route_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_routes.pop_front();
        if (rsp_bus.next_hop !== want.next_hop)
          report_mismatch($sformatf("next_hop %0h, want %0h", rsp_bus.next_hop, want.next_hop));
        if (rsp_bus.next_hop_valid !== want.next_hop_valid)
          report_mismatch($sformatf("next_hop_valid %0b, want %0b",
                                    rsp_bus.next_hop_valid, want.next_hop_valid));
        if (rsp_bus.hop_delay !== want.hop_delay)
          report_mismatch($sformatf("hop_delay %0h, want %0h", rsp_bus.hop_delay,
                                    want.hop_delay));
        if (rsp_bus.hit !== want.hit)
          report_mismatch($sformatf("hit %0b, want %0b", rsp_bus.hit, want.hit));
        if (rsp_bus.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
        if (rsp_bus.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", rsp_bus.entry_count,
                                    want.entry_count));
      end
    end
  end

  // response side stalls follow a slowly rotating pattern
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    if (!rst_ni || hold_rsp) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      case (stall_phase[7:6])
        2'd0:    rsp_bus.ready <= 1'b1;
        2'd1:    rsp_bus.ready <= (stall_phase[1:0] != 2'd3);
        2'd2:    rsp_bus.ready <= 1'($urandom_range(0, 1));
        default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // long response hold-off while requests keep coming
  initial begin
    wait (requests_taken >= HOLD_AFTER);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    probe_t            probes[$];
    route_t            blank;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    int                pick;
    int                slot;
    int                k;

    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.command     = CMD_LOOKUP;
    req_bus.address     = '0;
    req_bus.neighbor_id = '0;
    req_bus.entry_delay = '0;
    rsp_bus.ready       = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_DEF_NEIGHBOR;
    cfg_data_i          = '0;

    // empty table, no default route
    probes.push_back(chk_row(CMD_LOOKUP, 16'h0000, 8'hFF, 16'hFFFF,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b0, STAT_OK, 5'd0}));
    probes.push_back(chk_row(CMD_LOOKUP, 16'hFFFF, 8'h00, 16'h0000,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b0, STAT_OK, 5'd0}));
    probes.push_back(chk_row(CMD_INSERT, 16'h0000, 8'hFF, 16'hFFFF,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b0, STAT_OK, 5'd1}));
    probes.push_back(chk_row(CMD_INSERT, 16'hFFFF, 8'h00, 16'h0000,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b0, STAT_OK, 5'd2}));
    probes.push_back(chk_row(CMD_INSERT, 16'h0000, 8'h12, 16'h3456,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b1, STAT_DUP, 5'd2}));
    probes.push_back(chk_row(CMD_LOOKUP, 16'h0000, 8'h00, 16'h0000,
                             route_t'{8'hFF, 1'b1, 16'hFFFF, 1'b1, STAT_OK, 5'd2}));
    probes.push_back(chk_row(CMD_LOOKUP, 16'hFFFF, 8'hFF, 16'hFFFF,
                             route_t'{8'h00, 1'b1, 16'h0000, 1'b1, STAT_OK, 5'd2}));
    // default route set
    probes.push_back(cfg_row(CFG_DEF_NEIGHBOR, 16'h00FF));
    probes.push_back(cfg_row(CFG_DEF_VALID, 16'h0001));
    probes.push_back(cfg_row(CFG_DEF_DELAY, 16'hFFFF));
    probes.push_back(chk_row(CMD_LOOKUP, 16'h8000, 8'h00, 16'h0000,
                             route_t'{8'hFF, 1'b1, 16'hFFFF, 1'b0, STAT_OK, 5'd2}));
    // default route withdrawn, its delay still shows on a miss
    probes.push_back(cfg_row(CFG_DEF_VALID, 16'h0000));
    probes.push_back(cfg_row(CFG_DEF_DELAY, 16'h5A5A));
    probes.push_back(chk_row(CMD_LOOKUP, 16'h7FFF, 8'hFF, 16'hFFFF,
                             route_t'{8'h00, 1'b0, 16'h5A5A, 1'b0, STAT_OK, 5'd2}));
    // fill the remaining slots with one-hot addresses
    for (k = 0; k < TABLE_DEPTH - 2; k++)
      probes.push_back(req_row(CMD_INSERT, ADDR_W'(1) << k, NB_W'($urandom),
                               DELAY_W'($urandom)));
    probes.push_back(chk_row(CMD_INSERT, 16'h4000, 8'hA5, 16'hC3C3,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b0, STAT_FULL, 5'd16}));
    // duplicate wins over full
    probes.push_back(chk_row(CMD_INSERT, 16'h0001, 8'h5A, 16'h3C3C,
                             route_t'{8'h00, 1'b0, 16'h0000, 1'b1, STAT_DUP, 5'd16}));
    probes.push_back(req_row(CMD_LOOKUP, ADDR_W'(1) << (TABLE_DEPTH - 3), 8'h00, 16'h0000));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].kind == ROW_CONFIG) begin
        wait_table_idle();
        write_reg(probes[i].reg_idx, probes[i].reg_data);
      end else begin
        offer_request(probes[i].cmd, probes[i].addr, probes[i].nb, probes[i].dl,
                      probes[i].typed, probes[i].want);
      end
    end
    n_settings = 2;

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase > 0) begin
        wait_table_idle();
        case (phase)
          1: begin
            write_reg(CFG_DEF_NEIGHBOR, 16'h00FF);
            write_reg(CFG_DEF_VALID, 16'h0001);
            write_reg(CFG_DEF_DELAY, 16'hFFFF);
          end
          2: begin
            write_reg(CFG_DEF_NEIGHBOR, 16'h0000);
            write_reg(CFG_DEF_VALID, 16'h0000);
            write_reg(CFG_DEF_DELAY, 16'h0000);
          end
          default: begin
            write_reg(CFG_DEF_NEIGHBOR, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(CFG_DEF_VALID, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(CFG_DEF_DELAY, CFG_DATA_W'($urandom));
          end
        endcase
        n_settings++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, fwd_count - 1);
        addr = ADDR_W'($urandom);
        if (pick < 15) begin
          cmd = CMD_INSERT;
          if (pick < 8) addr = fwd_addr[slot];
        end else begin
          cmd = CMD_LOOKUP;
          if (pick < 70) addr = fwd_addr[slot];
          // one address bit off a stored entry
          else if (pick < 85) addr = fwd_addr[slot] ^ (ADDR_W'(1) << $urandom_range(0, 15));
        end
        offer_request(cmd, addr, NB_W'($urandom), DELAY_W'($urandom), 1'b0, blank);
      end
    end

    wait_table_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests: %0d hits, %0d misses, %0d stored, %0d duplicate, %0d full",
             requests_taken, n_hits, n_misses, n_stored, n_dups, n_full);
    $display("%0d default-route settings, one %0d-cycle response hold-off, %0d errors",
             n_settings, HOLD_CYCLES, error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
